// ===== rtl/uvs_pkg.sv =====
// Shared constants, types and rounding helpers for the UV sphere vertex generator.
package uvs_pkg;

  localparam int IN_DW  = 16;
  localparam int OUT_DW = 168;
  localparam int OUT_UW = 2;

  localparam logic [1:0] CFG_RADIUS   = 2'd0;
  localparam logic [1:0] CFG_SEGMENTS = 2'd1;
  localparam logic [1:0] CFG_RINGS    = 2'd2;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // sine/cosine pipeline depth: 4 front stages, 6 Horner steps of 3, quadrant stage
  localparam int SC_LAT = 23;
  localparam int NSTEP  = 6;

  localparam logic [29:0] PI_Q28  = 30'h3243F6A9;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Horner divisors and floor(2^32/k)
  localparam logic [7:0]  SIN_K   [5] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [31:0] SIN_RCP [5] = '{32'd39045157, 32'd59652323, 32'd102261126,
                                          32'd214748364, 32'd715827882};
  localparam logic [7:0]  COS_K   [6] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [31:0] COS_RCP [6] = '{32'd32537631, 32'd47721858, 32'd76695844,
                                          32'd143165576, 32'd357913941, 32'd2147483648};

  typedef struct packed {
    logic        oog;
    logic        quad;
    logic [15:0] vi;
    logic [15:0] below;
  } meta_t;

  // shift right with round half away from zero
  function automatic logic signed [63:0] shr_round(input logic signed [63:0] v, input int s);
    logic        neg;
    logic [63:0] mag;
    neg = v[63];
    mag = neg ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ===== rtl/uv_sphere_vertex_generator.sv =====
// UV sphere vertex generator: grid point to position, normal, uv and indices.
// The result path runs through the bit-pair divider and the Horner sin/cos pipeline.
// Throughput: one item per cycle; a skid register catches one result while the output waits, then in_tready drops.
// Reset: clears all valid bits; radius = 1.0, 32 segments, 16 rings.
module uv_sphere_vertex_generator import uvs_pkg::*; #(
  parameter int ANGLE_STAGES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // column[7:0], row[15:8]
  output logic              out_tvalid,
  input  logic              out_tready,
  // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v,
  // vertex_index, below_index, zero pad
  output logic [OUT_DW-1:0] out_tdata,
  output logic [OUT_UW-1:0] out_tuser,  // has_cell, out_of_grid
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int DK     = (ANGLE_STAGES > 16) ? ANGLE_STAGES : 16;
  localparam int NW     = 8 + DK;
  localparam int NWP    = NW + NW % 2;
  localparam int DIV_ST = NWP / 2;
  localparam int LAST   = DIV_ST + SC_LAT + 4;
  localparam int MD     = DIV_ST + SC_LAT + 3;
  localparam int TD     = SC_LAT + 3;

  logic [15:0] rad_r;
  logic [7:0]  seg_r, ring_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r  <= 16'd256;
      seg_r  <= 8'd32;
      ring_r <= 8'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RADIUS:   rad_r  <= cfg_data;
        CFG_SEGMENTS: seg_r  <= cfg_data[7:0];
        CFG_RINGS:    ring_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic            en;
  logic [LAST:0]   v_r;
  logic [7:0]      col_r, row_r;
  logic            o_v_r, sk_v_r;

  assign en        = !sk_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAST-1:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col_r <= in_tdata[7:0];
      row_r <= in_tdata[15:8];
    end
  end

  // grid checks and indices
  meta_t       meta;
  logic [16:0] vi17;

  always_comb begin
    vi17       = 17'(row_r) * 17'({1'b0, seg_r} + 9'd1) + 17'(col_r);
    meta.oog   = (seg_r == 8'd0) || (ring_r == 8'd0) || (col_r > seg_r) || (row_r > ring_r);
    meta.quad  = (col_r < seg_r) && (row_r < ring_r);
    meta.vi    = vi17[15:0];
    meta.below = meta.quad ? 16'(vi17 + 17'(seg_r) + 17'd1) : 16'd0;
  end

  meta_t meta_d_r [MD];

  always_ff @(posedge clk) begin
    if (en) begin
      meta_d_r[0] <= meta;
      for (int i = 1; i < MD; i++) begin
        meta_d_r[i] <= meta_d_r[i-1];
      end
    end
  end

  // dividers: theta phase, phi phase, tex_u, tex_v
  logic [NWP-1:0] num_w [4];
  logic [NWP-1:0] quo_w [4];
  logic [7:0]     den_w [4];

  always_comb begin
    num_w[0] = NWP'({col_r, ANGLE_STAGES'(seg_r[7:1])});
    num_w[1] = NWP'({row_r, (ANGLE_STAGES - 1)'(ring_r[7:1])});
    num_w[2] = NWP'({col_r, 16'(seg_r[7:1])});
    num_w[3] = NWP'({row_r, 16'(ring_r[7:1])});
    den_w[0] = seg_r;
    den_w[1] = ring_r;
    den_w[2] = seg_r;
    den_w[3] = ring_r;
  end

  genvar l;
  for (l = 0; l < 4; l++) begin : g_div
    uvs_div #(.W(NWP)) u_div (
      .clk (clk),
      .en  (en),
      .num (num_w[l]),
      .den (den_w[l]),
      .quo (quo_w[l])
    );
  end

  logic [33:0] tex_d_r [TD];

  always_ff @(posedge clk) begin
    if (en) begin
      tex_d_r[0] <= {quo_w[3][16:0], quo_w[2][16:0]};
      for (int i = 1; i < TD; i++) begin
        tex_d_r[i] <= tex_d_r[i-1];
      end
    end
  end

  logic signed [31:0] st_w, ct_w, sp_w, cp_w;

  uvs_sincos #(.A(ANGLE_STAGES)) u_theta (
    .clk   (clk),
    .en    (en),
    .phase (quo_w[0][ANGLE_STAGES-1:0]),
    .sin_q (st_w),
    .cos_q (ct_w)
  );

  uvs_sincos #(.A(ANGLE_STAGES)) u_phi (
    .clk   (clk),
    .en    (en),
    .phase (quo_w[1][ANGLE_STAGES-1:0]),
    .sin_q (sp_w),
    .cos_q (cp_w)
  );

  // direction, scaling and output formatting
  logic signed [63:0] n0p_r, n2p_r;
  logic signed [31:0] ny1_r, nx_r, ny_r, nz_r;
  logic signed [48:0] px_r, py_r, pz_r;
  logic signed [15:0] nqx_r, nqy_r, nqz_r;

  function automatic logic signed [15:0] norm_q14(input logic signed [31:0] n);
    logic signed [63:0] r;
    r = shr_round(64'(n), 16);
    if (r > 64'sd16384) begin
      r = 64'sd16384;
    end else if (r < -64'sd16384) begin
      r = -64'sd16384;
    end
    return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      n0p_r <= 64'(ct_w) * 64'(sp_w);
      n2p_r <= 64'(st_w) * 64'(sp_w);
      ny1_r <= cp_w;
      nx_r  <= 32'(shr_round(n0p_r, 30));
      nz_r  <= 32'(shr_round(n2p_r, 30));
      ny_r  <= ny1_r;
      px_r  <= $signed({33'b0, rad_r}) * 49'(nx_r);
      py_r  <= $signed({33'b0, rad_r}) * 49'(ny_r);
      pz_r  <= $signed({33'b0, rad_r}) * 49'(nz_r);
      nqx_r <= norm_q14(nx_r);
      nqy_r <= norm_q14(ny_r);
      nqz_r <= norm_q14(nz_r);
    end
  end

  logic [OUT_DW-1:0]  res_d, res_d_r;
  logic [OUT_UW-1:0]  res_u, res_u_r;
  logic signed [63:0] pxs, pys, pzs;
  meta_t              mf;

  always_comb begin
    mf  = meta_d_r[MD-1];
    pxs = shr_round(64'(px_r), 30);
    pys = shr_round(64'(py_r), 30);
    pzs = shr_round(64'(pz_r), 30);
    if (mf.oog) begin
      res_d = '0;
      res_u = 2'b10;
    end else begin
      res_d = {3'b0, mf.below, mf.vi, tex_d_r[TD-1],
               nqz_r, nqy_r, nqx_r,
               pzs[16:0], pys[16:0], pxs[16:0]};
      res_u = {1'b0, mf.quad};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_d_r <= res_d;
      res_u_r <= res_u;
    end
  end

  // output register with one skid entry
  logic              take, push;
  logic              o_v_nxt, sk_v_nxt;
  logic [OUT_DW-1:0] o_d_r, o_d_nxt, sk_d_r, sk_d_nxt;
  logic [OUT_UW-1:0] o_u_r, o_u_nxt, sk_u_r, sk_u_nxt;

  always_comb begin
    take     = o_v_r && out_tready;
    push     = en && v_r[LAST];
    o_v_nxt  = o_v_r;
    sk_v_nxt = sk_v_r;
    o_d_nxt  = o_d_r;
    o_u_nxt  = o_u_r;
    sk_d_nxt = sk_d_r;
    sk_u_nxt = sk_u_r;
    if (!o_v_r || take) begin
      if (sk_v_r) begin
        o_v_nxt  = 1'b1;
        o_d_nxt  = sk_d_r;
        o_u_nxt  = sk_u_r;
        sk_v_nxt = 1'b0;
      end else begin
        o_v_nxt = push;
        o_d_nxt = res_d_r;
        o_u_nxt = res_u_r;
      end
    end else if (push) begin
      sk_v_nxt = 1'b1;
      sk_d_nxt = res_d_r;
      sk_u_nxt = res_u_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r  <= 1'b0;
      sk_v_r <= 1'b0;
    end else begin
      o_v_r  <= o_v_nxt;
      sk_v_r <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_d_r  <= o_d_nxt;
    o_u_r  <= o_u_nxt;
    sk_d_r <= sk_d_nxt;
    sk_u_r <= sk_u_nxt;
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = o_d_r;
  assign out_tuser  = o_u_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> o_v_r)
    else $error("skid entry held without an output item");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sk_v_r) |-> $past(o_v_r && !out_tready))
    else $error("skid filled while output was free");

  a_oog_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata == '0 && !out_tuser[0]))
    else $error("out-of-grid item carries nonzero fields");

endmodule

// ===== rtl/uvs_div.sv =====
// Pipelined restoring divider, two quotient bits per stage, 8-bit divisor.
module uvs_div #(
  parameter int W = 24
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] num,
  input  logic [7:0]   den,
  output logic [W-1:0] quo
);

  localparam int ST = W / 2;

  logic [7:0]   rem_r [ST];
  logic [W-1:0] wrk_r [ST];

  genvar s;
  for (s = 0; s < ST; s++) begin : g_st
    logic [7:0]   rem_i, rem_m, rem_o;
    logic [W-1:0] wrk_i, wrk_m, wrk_o;
    logic [8:0]   t0, t1;
    logic         ge0, ge1;

    if (s == 0) begin : g_first
      assign rem_i = '0;
      assign wrk_i = num;
    end else begin : g_next
      assign rem_i = rem_r[s-1];
      assign wrk_i = wrk_r[s-1];
    end

    always_comb begin
      t0    = {rem_i, wrk_i[W-1]};
      ge0   = t0 >= {1'b0, den};
      rem_m = ge0 ? 8'(t0 - {1'b0, den}) : t0[7:0];
      wrk_m = {wrk_i[W-2:0], ge0};
      t1    = {rem_m, wrk_m[W-1]};
      ge1   = t1 >= {1'b0, den};
      rem_o = ge1 ? 8'(t1 - {1'b0, den}) : t1[7:0];
      wrk_o = {wrk_m[W-2:0], ge1};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_o;
        wrk_r[s] <= wrk_o;
      end
    end
  end

  assign quo = wrk_r[ST-1];

endmodule

// ===== rtl/uvs_sincos.sv =====
// Pipelined Q1.30 sine and cosine of a binary phase, Horner Taylor series.
module uvs_sincos import uvs_pkg::*; #(
  parameter int A = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [A-1:0]       phase,
  output logic signed [31:0] sin_q,
  output logic signed [31:0] cos_q
);

  localparam int PW = A + 28;
  localparam logic [PW:0] XR_HALF = (PW + 1)'(1) << (A - 4);

  logic [1:0]    q1_r, q2_r, q3_r, q4_r;
  logic [PW-1:0] rp_r;
  logic [30:0]   x2_r, x3_r, x4_r;
  logic [61:0]   xx_r;
  logic [31:0]   xsq_r;
  logic [PW:0]   xr_sum;
  logic [62:0]   xx_sum;

  always_comb begin
    xr_sum = {1'b0, rp_r} + XR_HALF;
    xx_sum = {1'b0, xx_r} + 63'(64'd1 << 29);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_r  <= phase[A-1:A-2];
      rp_r  <= PW'(phase[A-3:0]) * PW'(PI_Q28);
      q2_r  <= q1_r;
      x2_r  <= xr_sum[A+27:A-3];
      q3_r  <= q2_r;
      x3_r  <= x2_r;
      xx_r  <= 62'(x2_r) * 62'(x2_r);
      q4_r  <= q3_r;
      x4_r  <= x3_r;
      xsq_r <= xx_sum[61:30];
    end
  end

  logic [62:0] pc_r  [NSTEP];
  logic [62:0] ps_r  [NSTEP];
  logic [1:0]  aq_r  [NSTEP];
  logic [30:0] ax_r  [NSTEP];
  logic [31:0] ax2_r [NSTEP];
  logic [31:0] mc_r  [NSTEP];
  logic [31:0] qec_r [NSTEP];
  logic [31:0] ms_r  [NSTEP];
  logic [31:0] qes_r [NSTEP];
  logic [1:0]  bq_r  [NSTEP];
  logic [30:0] bx_r  [NSTEP];
  logic [31:0] bx2_r [NSTEP];
  logic [30:0] tc_r  [NSTEP];
  logic [30:0] ts_r  [NSTEP];
  logic [1:0]  cq_r  [NSTEP];
  logic [30:0] cx_r  [NSTEP];
  logic [31:0] cx2_r [NSTEP];

  genvar j;
  for (j = 0; j < NSTEP; j++) begin : g_step
    logic [30:0]        tci, tsi, xi;
    logic [31:0]        x2i, mop, mcw, rc, qc;
    logic [1:0]         qi;
    logic [63:0]        pmc;
    logic [39:0]        qkc;
    logic signed [33:0] dc;

    if (j == 0) begin : g_first
      assign tci = ONE_Q30;
      assign tsi = ONE_Q30;
      assign xi  = x4_r;
      assign x2i = xsq_r;
      assign qi  = q4_r;
    end else begin : g_next
      assign tci = tc_r[j-1];
      assign tsi = ts_r[j-1];
      assign xi  = cx_r[j-1];
      assign x2i = cx2_r[j-1];
      assign qi  = cq_r[j-1];
    end

    always_comb begin
      mop = (j == NSTEP - 1) ? {1'b0, xi} : x2i;
      mcw = pc_r[j][61:30];
      pmc = {32'b0, mcw} * {32'b0, COS_RCP[j]};
      qkc = 40'(qec_r[j]) * 40'(COS_K[j]);
      rc  = mc_r[j] - qkc[31:0];
      qc  = qec_r[j] + 32'(rc >= 32'(COS_K[j]));
      dc  = $signed({3'b0, ONE_Q30}) - $signed({2'b0, qc});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pc_r[j]  <= 63'(x2i) * 63'(tci);
        ps_r[j]  <= 63'(mop) * 63'(tsi);
        aq_r[j]  <= qi;
        ax_r[j]  <= xi;
        ax2_r[j] <= x2i;
        mc_r[j]  <= mcw;
        qec_r[j] <= pmc[63:32];
        bq_r[j]  <= aq_r[j];
        bx_r[j]  <= ax_r[j];
        bx2_r[j] <= ax2_r[j];
        tc_r[j]  <= dc[33] ? '0 : dc[30:0];
        cq_r[j]  <= bq_r[j];
        cx_r[j]  <= bx_r[j];
        cx2_r[j] <= bx2_r[j];
      end
    end

    if (j < NSTEP - 1) begin : g_sin_step
      logic [31:0]        msw, rs, qs;
      logic [63:0]        pms;
      logic [39:0]        qks;
      logic signed [33:0] ds;

      always_comb begin
        msw = ps_r[j][61:30];
        pms = {32'b0, msw} * {32'b0, SIN_RCP[j]};
        qks = 40'(qes_r[j]) * 40'(SIN_K[j]);
        rs  = ms_r[j] - qks[31:0];
        qs  = qes_r[j] + 32'(rs >= 32'(SIN_K[j]));
        ds  = $signed({3'b0, ONE_Q30}) - $signed({2'b0, qs});
      end

      always_ff @(posedge clk) begin
        if (en) begin
          ms_r[j]  <= msw;
          qes_r[j] <= pms[63:32];
          ts_r[j]  <= ds[33] ? '0 : ds[30:0];
        end
      end
    end else begin : g_sin_final
      logic [62:0] sr;

      always_comb begin
        sr = ps_r[j] + 63'(64'd1 << 29);
      end

      always_ff @(posedge clk) begin
        if (en) begin
          ms_r[j]  <= sr[61:30];
          qes_r[j] <= '0;
          ts_r[j]  <= (ms_r[j] > 32'(ONE_Q30)) ? ONE_Q30 : ms_r[j][30:0];
        end
      end
    end
  end

  logic signed [31:0] s_w, c_w, sin_nxt, cos_nxt, sin_r, cos_r;

  always_comb begin
    s_w = $signed({1'b0, ts_r[NSTEP-1]});
    c_w = $signed({1'b0, tc_r[NSTEP-1]});
    case (cq_r[NSTEP-1])
      QUAD_0: begin
        sin_nxt = s_w;
        cos_nxt = c_w;
      end
      QUAD_1: begin
        sin_nxt = c_w;
        cos_nxt = -s_w;
      end
      QUAD_2: begin
        sin_nxt = -s_w;
        cos_nxt = -c_w;
      end
      QUAD_3: begin
        sin_nxt = -c_w;
        cos_nxt = s_w;
      end
      default: begin
        sin_nxt = '0;
        cos_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

// ===== tb/sv/uv_sphere_vertex_generator_tb.sv =====
// Testbench for the UV sphere vertex generator: predicted vertex checks over streams.
`timescale 1ns / 1ps
module uv_sphere_vertex_generator_tb import uvs_pkg::*;;

  localparam int ANG = 16;

  typedef struct {
    logic signed [16:0] pos_x, pos_y, pos_z;
    logic signed [15:0] nrm_x, nrm_y, nrm_z;
    logic [16:0] tex_u, tex_v;
    logic [15:0] vidx, below;
    logic        quad, oog;
  } vertex_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_DW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DW-1:0] out_tdata;
  logic [OUT_UW-1:0] out_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic [15:0] radius_q;
  logic [7:0] seg_cnt, ring_cnt;
  vertex_t vertex_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  uv_sphere_vertex_generator #(.ANGLE_STAGES(ANG)) dut (.*);

  initial forever #5 clk = ~clk;

  initial begin
    #200ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic longint round_shift(longint v, int s);
    longint mag;
    mag = v < 0 ? -v : v;
    mag = (mag + (64'sd1 <<< (s - 1))) >>> s;
    return v < 0 ? -mag : mag;
  endfunction

  function automatic longint unit_clamp(longint t);
    if (t < 0) return 0;
    if (t > (64'sd1 <<< 30)) return 64'sd1 <<< 30;
    return t;
  endfunction

  task automatic phase_sincos(input longint phase, output longint s_o, output longint c_o);
    longint sk[5], ck[6];
    longint one, r, x, x2, t, s, c;
    int q;
    sk = '{110, 72, 42, 20, 6};
    ck = '{132, 90, 56, 30, 12, 2};
    one = 64'sd1 <<< 30;
    q = int'((phase >> (ANG - 2)) & 3);
    r = phase & ((64'sd1 <<< (ANG - 2)) - 1);
    x = (r * 64'sh3243F6A9 + (64'sd1 <<< (ANG - 4))) >>> (ANG - 3);
    x2 = (x * x + (64'sd1 <<< 29)) >>> 30;
    t = one;
    for (int i = 0; i < 5; i++) t = unit_clamp(one - ((x2 * t) >>> 30) / sk[i]);
    s = unit_clamp((x * t + (64'sd1 <<< 29)) >>> 30);
    t = one;
    for (int i = 0; i < 6; i++) t = unit_clamp(one - ((x2 * t) >>> 30) / ck[i]);
    c = t;
    case (q)
      QUAD_0: begin s_o = s; c_o = c; end
      QUAD_1: begin s_o = c; c_o = -s; end
      QUAD_2: begin s_o = -s; c_o = -c; end
      default: begin s_o = -c; c_o = s; end
    endcase
  endtask

  task automatic predict_vertex(input logic [7:0] col, input logic [7:0] row,
                                output vertex_t v);
    longint sg, rg, pt, pp, st, ct, sp, cp, vi, p, nq;
    longint n[3];
    v = '{default: '0};
    sg = seg_cnt;
    rg = ring_cnt;
    if (sg == 0 || rg == 0 || col > sg || row > rg) begin
      v.oog = 1'b1;
      return;
    end
    pt = ((longint'(col) << ANG) + sg / 2) / sg & ((64'sd1 <<< ANG) - 1);
    pp = ((longint'(row) << (ANG - 1)) + rg / 2) / rg;
    phase_sincos(pt, st, ct);
    phase_sincos(pp, sp, cp);
    n[0] = round_shift(ct * sp, 30);
    n[1] = cp;
    n[2] = round_shift(st * sp, 30);
    for (int j = 0; j < 3; j++) begin
      p = round_shift(longint'(radius_q) * n[j], 30);
      nq = round_shift(n[j], 16);
      if (nq > 16384) nq = 16384;
      if (nq < -16384) nq = -16384;
      case (j)
        0: begin v.pos_x = p[16:0]; v.nrm_x = nq[15:0]; end
        1: begin v.pos_y = p[16:0]; v.nrm_y = nq[15:0]; end
        default: begin v.pos_z = p[16:0]; v.nrm_z = nq[15:0]; end
      endcase
    end
    v.tex_u = 17'(((longint'(col) << 16) + sg / 2) / sg);
    v.tex_v = 17'(((longint'(row) << 16) + rg / 2) / rg);
    vi = row * (sg + 1) + col;
    v.quad = col < sg && row < rg;
    v.vidx = vi[15:0];
    v.below = v.quad ? 16'(vi + sg + 1) : 16'd0;
  endtask

  task automatic send_point(input logic [7:0] col, input logic [7:0] row);
    vertex_t v;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    predict_vertex(col, row, v);
    in_tvalid <= 1;
    in_tdata <= {row, col};
    do @(posedge clk); while (!in_tready);
    vertex_q.insert(vertex_q.size(), v);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      CFG_RADIUS: radius_q = val;
      CFG_SEGMENTS: seg_cnt = val[7:0];
      CFG_RINGS: ring_cnt = val[7:0];
      default: ;
    endcase
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0d got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && hold_cycles > 0) begin
      out_tready <= 0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (vertex_q.size() == 0) begin
        $error("result with no expectation");
        errors++;
      end else begin
        e = vertex_q.pop_front();
        check_field("pos_x", e.pos_x, $signed(out_tdata[16:0]));
        check_field("pos_y", e.pos_y, $signed(out_tdata[33:17]));
        check_field("pos_z", e.pos_z, $signed(out_tdata[50:34]));
        check_field("normal_x", e.nrm_x, $signed(out_tdata[66:51]));
        check_field("normal_y", e.nrm_y, $signed(out_tdata[82:67]));
        check_field("normal_z", e.nrm_z, $signed(out_tdata[98:83]));
        check_field("tex_u", e.tex_u, out_tdata[115:99]);
        check_field("tex_v", e.tex_v, out_tdata[132:116]);
        check_field("vertex_index", e.vidx, out_tdata[148:133]);
        check_field("below_index", e.below, out_tdata[164:149]);
        check_field("has_cell", e.quad, out_tuser[0]);
        check_field("out_of_grid", e.oog, out_tuser[1]);
      end
    end
  end

  task automatic test_directed();
    send_point(0, 0);
    send_point(32, 16);
    send_point(0, 16);
    send_point(8, 8);
    send_point(31, 15);
    send_point(33, 0);
    send_point(0, 17);
    send_point(255, 255);
    write_reg(CFG_RADIUS, 16'hFFFF);
    write_reg(CFG_SEGMENTS, 255);
    write_reg(CFG_RINGS, 255);
    send_point(255, 255);
    send_point(254, 254);
    send_point(128, 128);
    send_point(170, 85);
    write_reg(CFG_RADIUS, 0);
    write_reg(CFG_SEGMENTS, 1);
    write_reg(CFG_RINGS, 1);
    send_point(0, 0);
    send_point(1, 1);
    send_point(1, 0);
    send_point(2, 1);
    write_reg(CFG_SEGMENTS, 0);
    send_point(0, 0);
    write_reg(CFG_SEGMENTS, 4);
    write_reg(CFG_RINGS, 0);
    send_point(0, 0);
    write_reg(2'd3, 16'h1234);
    send_point(1, 1);
  endtask

  task automatic random_phase(input int n_items);
    logic [7:0] c, r;
    write_reg(CFG_RADIUS, 16'($urandom));
    write_reg(CFG_SEGMENTS, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 40)));
    write_reg(CFG_RINGS, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 40)));
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(9) == 0) begin
        c = 8'($urandom);
        r = 8'($urandom);
      end else begin
        c = 8'($urandom_range(seg_cnt));
        r = 8'($urandom_range(ring_cnt));
      end
      send_point(c, r);
    end
  endtask

  task automatic test_random_idles();
    send_idle_pct = 23;
    recv_idle_pct = 80;
    repeat (4) random_phase(110);
    send_idle_pct = 80;
    recv_idle_pct = 23;
    repeat (4) random_phase(110);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) random_phase(110);
  endtask

  task automatic test_backpressure();
    drain();
    hold_cycles = 300;
    random_phase(100);
  endtask

  initial begin
    radius_q = 256;
    seg_cnt = 32;
    ring_cnt = 16;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random_idles();
    test_backpressure();
    drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/uvs_pkg.sv
rtl/uvs_div.sv
rtl/uvs_sincos.sv
rtl/uv_sphere_vertex_generator.sv
tb/sv/uv_sphere_vertex_generator_tb.sv
